/* design/number_to_seven_segment_defines.svh */
// Assertion macros for the number_to_seven_segment RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef NUMBER_TO_SEVEN_SEGMENT_DEFINES_SVH
`define NUMBER_TO_SEVEN_SEGMENT_DEFINES_SVH

// ante must be followed by cons in the same cycle
`define N7S_ASSERT_IMPLIES(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// cond holds at every edge out of reset
`define N7S_ASSERT_ALWAYS(name, clk, rstn, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error(msg);

`endif

/* design/num7seg_pkg.sv */
// Shared types, constants and glyph table for the seven-segment number formatter.
// No dependencies; imported by every module of the block.
package num7seg_pkg;

    localparam int VALUE_W     = 40;
    localparam int SEG_W       = 8;
    localparam int TDATA_W     = 40;
    localparam int TUSER_W     = 1;
    localparam int BASE_W      = 5;
    localparam int FRAC_W      = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int BASE_IDX_W  = 4;
    localparam int DIGIT_W     = 4;

    localparam int DEFAULT_NUMERIC_DIGITS = 4;
    localparam int DEFAULT_FRACTION_BITS  = 16;
    localparam int QUEUE_DEPTH            = 2;
    localparam int DIGIT_SLOTS            = 4;
    localparam int SLOT_IDX_W             = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_BASE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRACTION_DIGITS = 2'd1;

    localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
    localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;
    localparam logic [FRAC_W-1:0] FRAC_RESET = 3'd2;

    localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
    localparam logic [SEG_W-1:0] SEG_DOT   = 8'h80;

    localparam logic [SEG_W-1:0] GLYPH [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h5F, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
    };

    typedef struct packed {
        logic              neg;
        logic [BASE_W-1:0] base;
        logic [FRAC_W-1:0] frac;
    } item_ctrl_t;

    localparam int ITEM_CTRL_W = $bits(item_ctrl_t);

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_POW,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SEARCH,
        B_DIV,
        B_FIX,
        B_DONE
    } back_state_t;

endpackage

/* design/num7seg_queue.sv */
// Small FIFO between the classify front and the formatting back end.
// Depends on num7seg_pkg and number_to_seven_segment_defines.svh.
`include "number_to_seven_segment_defines.svh"

module num7seg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output num7seg_pkg::queue_status_t status
);
    import num7seg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    `N7S_ASSERT_IMPLIES(a_no_push_full, aclk, aresetn, push, count_reg < CNT_W'(DEPTH), "push into full queue")
    `N7S_ASSERT_IMPLIES(a_no_pop_empty, aclk, aresetn, pop, count_reg != '0, "pop from empty queue")
    `N7S_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH), "queue count out of range")

endmodule

/* design/num7seg_front.sv */
// Front end: accepts a word, takes sign and magnitude, clamps the base and
// builds base^digits serially. Depends on num7seg_pkg.
module num7seg_front #(
    parameter int NUMERIC_DIGITS = 4,
    parameter int ENTRY_W        = 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [num7seg_pkg::VALUE_W-1:0]    s_tdata,
    input  logic [num7seg_pkg::BASE_W-1:0]     cfg_base,
    input  logic [num7seg_pkg::FRAC_W-1:0]     cfg_frac,
    input  num7seg_pkg::queue_status_t         q_status,
    output logic                               push,
    output logic [ENTRY_W-1:0]                 push_data
);
    import num7seg_pkg::*;

    localparam int POW_W = 4 * NUMERIC_DIGITS + 1;
    localparam int CNT_W = $clog2(NUMERIC_DIGITS + 1);

    front_state_t     state_reg, state_next;
    item_ctrl_t       ctrl_reg, ctrl_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic [POW_W-1:0] pow_reg, pow_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;
    logic             neg_in;

    assign accept = s_tvalid && s_tready;
    assign neg_in = s_tdata[VALUE_W-1];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_tvalid) state_next = F_POW;
            end
            F_POW: begin
                if (cnt_reg == CNT_W'(1)) state_next = F_PUSH;
            end
            F_PUSH: begin
                if (!q_status.full) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == F_IDLE);
        push     = (state_reg == F_PUSH) && !q_status.full;
    end

    always_comb begin
        ctrl_next = ctrl_reg;
        mag_next  = mag_reg;
        pow_next  = pow_reg;
        cnt_next  = cnt_reg;
        if (accept) begin
            ctrl_next.neg = neg_in;
            priority if (cfg_base < BASE_MIN) begin
                ctrl_next.base = BASE_MIN;
            end else if (cfg_base > BASE_MAX) begin
                ctrl_next.base = BASE_MAX;
            end else begin
                ctrl_next.base = cfg_base;
            end
            ctrl_next.frac = cfg_frac;
            mag_next = neg_in ? VALUE_W'(~s_tdata + VALUE_W'(1)) : s_tdata;
            pow_next = POW_W'(1);
            cnt_next = neg_in ? CNT_W'(NUMERIC_DIGITS - 1) : CNT_W'(NUMERIC_DIGITS);
        end else if (state_reg == F_POW) begin
            pow_next = POW_W'(pow_reg * POW_W'(ctrl_reg.base));
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        ctrl_reg <= ctrl_next;
        mag_reg  <= mag_next;
        pow_reg  <= pow_next;
        cnt_reg  <= cnt_next;
    end

    assign push_data = {ctrl_reg, pow_reg, mag_reg};

endmodule

/* design/num7seg_back.sv */
// Back end: finds the fraction digit count that fits, extracts digits by
// reciprocal multiply with one correction, and holds the output register.
// Depends on num7seg_pkg.
module num7seg_back #(
    parameter int NUMERIC_DIGITS = 4,
    parameter int FRACTION_BITS  = 16,
    parameter int ENTRY_W        = 1
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  num7seg_pkg::queue_status_t       q_status,
    input  logic [ENTRY_W-1:0]               pop_data,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [num7seg_pkg::TDATA_W-1:0]  m_tdata,  // seg_pos0..seg_pos4, 8 bits each
    output logic [num7seg_pkg::TUSER_W-1:0]  m_tuser   // overflow
);
    import num7seg_pkg::*;

    localparam int POW_W  = 4 * NUMERIC_DIGITS + 1;
    localparam int LW     = 4 * NUMERIC_DIGITS + FRACTION_BITS + 1;
    localparam int PW_MIN = 4 * NUMERIC_DIGITS + FRACTION_BITS + 4;
    localparam int PW     = (VALUE_W > PW_MIN) ? VALUE_W : PW_MIN;
    localparam int CW     = PW + 1;
    localparam int NUMW   = 4 * NUMERIC_DIGITS;
    localparam int RW     = NUMW + 1;
    localparam int S      = NUMW + 1;
    localparam int PRW    = NUMW + RW;
    localparam logic [63:0] ONE_S = 64'd1 << S;
    localparam logic [CW-1:0] HALF = CW'(1) << (FRACTION_BITS - 1);

    // entry k holds floor(2^S / (k + 1)) for k >= 1; entry 0 holds zero
    localparam logic [RW-1:0] RECIP [16] = '{
        RW'(0),
        RW'(ONE_S / 64'd2),  RW'(ONE_S / 64'd3),  RW'(ONE_S / 64'd4),
        RW'(ONE_S / 64'd5),  RW'(ONE_S / 64'd6),  RW'(ONE_S / 64'd7),
        RW'(ONE_S / 64'd8),  RW'(ONE_S / 64'd9),  RW'(ONE_S / 64'd10),
        RW'(ONE_S / 64'd11), RW'(ONE_S / 64'd12), RW'(ONE_S / 64'd13),
        RW'(ONE_S / 64'd14), RW'(ONE_S / 64'd15), RW'(ONE_S / 64'd16)
    };

    back_state_t          state_reg, state_next;
    item_ctrl_t           ctrl_reg, ctrl_next;
    logic [LW-1:0]        limit_reg, limit_next;
    logic [PW-1:0]        p_reg, p_next;
    logic [FRAC_W-1:0]    k_reg, k_next;
    logic [FRAC_W-1:0]    f_reg, f_next;
    logic [NUMW-1:0]      num_reg, num_next;
    logic [NUMW-1:0]      qest_reg, qest_next;
    logic [SLOT_IDX_W-1:0] j_reg, j_next;
    logic                 sign_done_reg, sign_done_next;
    logic                 ovf_reg, ovf_next;
    logic [SEG_W-1:0]     slot_reg [DIGIT_SLOTS];
    logic [SEG_W-1:0]     slot_next [DIGIT_SLOTS];
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [TUSER_W-1:0]   m_tuser_reg, m_tuser_next;

    item_ctrl_t           in_ctrl;
    logic [POW_W-1:0]     in_pow;
    logic [VALUE_W-1:0]   in_mag;
    logic [CW-1:0]        sum;
    logic                 fit;
    logic [BASE_IDX_W-1:0] recip_idx;
    logic [PRW-1:0]       recip_prod;
    logic [NUMW-1:0]      qb;
    logic [NUMW-1:0]      rem;
    logic [5:0]           rem6;
    logic                 fix;
    logic [DIGIT_W-1:0]   digit;
    logic [NUMW-1:0]      q;
    logic                 written;
    logic                 dot;
    logic                 load_out;

    assign in_ctrl = item_ctrl_t'(pop_data[ENTRY_W-1 -: ITEM_CTRL_W]);
    assign in_pow  = pop_data[VALUE_W +: POW_W];
    assign in_mag  = pop_data[VALUE_W-1:0];

    assign sum        = CW'(p_reg) + HALF;
    assign fit        = sum < CW'(limit_reg);
    assign recip_idx  = BASE_IDX_W'(ctrl_reg.base - BASE_W'(1));
    assign recip_prod = PRW'(num_reg) * PRW'(RECIP[recip_idx]);
    assign qb         = NUMW'(qest_reg * NUMW'(ctrl_reg.base));
    assign rem        = num_reg - qb;
    assign rem6       = rem[5:0];
    assign fix        = rem6 >= 6'(ctrl_reg.base);
    assign digit      = fix ? DIGIT_W'(rem6 - 6'(ctrl_reg.base)) : rem6[DIGIT_W-1:0];
    assign q          = fix ? qest_reg + NUMW'(1) : qest_reg;
    assign written    = (num_reg != '0) || (FRAC_W'(j_reg) <= f_reg);
    assign dot        = (f_reg != '0) && (FRAC_W'(j_reg) == f_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (!q_status.empty) state_next = B_SEARCH;
            end
            B_SEARCH: begin
                priority if (fit) begin
                    if (k_reg == ctrl_reg.frac) state_next = B_DIV;
                end else if (k_reg == '0) begin
                    state_next = B_DONE;
                end else begin
                    state_next = B_DIV;
                end
            end
            B_DIV: state_next = B_FIX;
            B_FIX: begin
                state_next = (j_reg == SLOT_IDX_W'(DIGIT_SLOTS - 1)) ? B_DONE : B_DIV;
            end
            B_DONE: begin
                if (!m_tvalid_reg || m_tready) state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        pop      = (state_reg == B_IDLE) && !q_status.empty;
        load_out = (state_reg == B_DONE) && (!m_tvalid_reg || m_tready);
        m_tvalid = m_tvalid_reg;
        m_tdata  = m_tdata_reg;
        m_tuser  = m_tuser_reg;
    end

    always_comb begin
        ctrl_next      = ctrl_reg;
        limit_next     = limit_reg;
        p_next         = p_reg;
        k_next         = k_reg;
        f_next         = f_reg;
        num_next       = num_reg;
        qest_next      = qest_reg;
        j_next         = j_reg;
        sign_done_next = sign_done_reg;
        ovf_next       = ovf_reg;
        slot_next      = slot_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (pop) begin
                    ctrl_next  = in_ctrl;
                    limit_next = LW'(in_pow) << FRACTION_BITS;
                    p_next     = PW'(in_mag);
                    k_next     = '0;
                    ovf_next   = 1'b0;
                end
            end
            B_SEARCH: begin
                j_next         = '0;
                sign_done_next = 1'b0;
                if (fit) begin
                    num_next = sum[FRACTION_BITS +: NUMW];
                    f_next   = k_reg;
                    if (k_reg != ctrl_reg.frac) begin
                        p_next = PW'(p_reg * PW'(ctrl_reg.base));
                        k_next = k_reg + FRAC_W'(1);
                    end
                end else if (k_reg == '0) begin
                    ovf_next = 1'b1;
                end
            end
            B_DIV: begin
                qest_next = recip_prod[S +: NUMW];
            end
            B_FIX: begin
                priority if (written) begin
                    slot_next[j_reg] = GLYPH[digit] | (dot ? SEG_DOT : SEG_BLANK);
                end else if (ctrl_reg.neg && !sign_done_reg) begin
                    slot_next[j_reg] = SEG_MINUS;
                    sign_done_next   = 1'b1;
                end else begin
                    slot_next[j_reg] = SEG_BLANK;
                end
                num_next = q;
                j_next   = j_reg + SLOT_IDX_W'(1);
            end
            B_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            if (ovf_reg) begin
                m_tdata_next = {SEG_MINUS, SEG_MINUS, SEG_BLANK, SEG_MINUS, SEG_MINUS};
                m_tuser_next = 1'b1;
            end else begin
                m_tdata_next = {slot_reg[0], slot_reg[1], SEG_BLANK, slot_reg[2], slot_reg[3]};
                m_tuser_next = 1'b0;
            end
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ctrl_reg      <= ctrl_next;
        limit_reg     <= limit_next;
        p_reg         <= p_next;
        k_reg         <= k_next;
        f_reg         <= f_next;
        num_reg       <= num_next;
        qest_reg      <= qest_next;
        j_reg         <= j_next;
        sign_done_reg <= sign_done_next;
        ovf_reg       <= ovf_next;
        slot_reg      <= slot_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

endmodule

/* design/number_to_seven_segment.sv */
// Seven-segment number formatter: takes a signed Q23.16 word and returns five
// segment bytes plus an overflow flag. The front takes no new word until it
// has pushed the last one, and builds base^digits (one digit fewer for a
// negative word) with a serial multiply. A two-entry queue passes the word to
// the back end. The back end makes one fit test per fraction digit count
// tried, then a reciprocal divide and its correction for each digit slot.
// A word that shows dashes skips the divide. The slower side sets the
// sustained rate. Results wait in an output register, so the front keeps
// taking words while m_tready is low until the queue fills.
module number_to_seven_segment #(
    parameter int NUMERIC_DIGITS = num7seg_pkg::DEFAULT_NUMERIC_DIGITS,
    parameter int FRACTION_BITS  = num7seg_pkg::DEFAULT_FRACTION_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [num7seg_pkg::VALUE_W-1:0]      s_tdata,   // value
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [num7seg_pkg::TDATA_W-1:0]      m_tdata,   // seg_pos0, seg_pos1, seg_pos2,
                                                            // seg_pos3, seg_pos4
    output logic [num7seg_pkg::TUSER_W-1:0]      m_tuser,   // overflow
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [num7seg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [num7seg_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import num7seg_pkg::*;

    localparam int POW_W   = 4 * NUMERIC_DIGITS + 1;
    localparam int ENTRY_W = ITEM_CTRL_W + POW_W + VALUE_W;

    logic [BASE_W-1:0]  base_reg, base_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] push_data;
    logic [ENTRY_W-1:0] pop_data;
    queue_status_t      q_status;

    assign cfg_ready = 1'b1;

    always_comb begin
        base_next = base_reg;
        frac_next = frac_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_NUMBER_BASE:     base_next = cfg_data;
                CFG_FRACTION_DIGITS: frac_next = cfg_data[FRAC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RESET;
            frac_reg <= FRAC_RESET;
        end else begin
            base_reg <= base_next;
            frac_reg <= frac_next;
        end
    end

    num7seg_front #(
        .NUMERIC_DIGITS(NUMERIC_DIGITS),
        .ENTRY_W       (ENTRY_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg_base (base_reg),
        .cfg_frac (frac_reg),
        .q_status (q_status),
        .push     (push),
        .push_data(push_data)
    );

    num7seg_queue #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .pop_data (pop_data),
        .status   (q_status)
    );

    num7seg_back #(
        .NUMERIC_DIGITS(NUMERIC_DIGITS),
        .FRACTION_BITS (FRACTION_BITS),
        .ENTRY_W       (ENTRY_W)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_status(q_status),
        .pop_data(pop_data),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

/* dv/number_to_seven_segment_test.sv */
// Self-checking testbench for number_to_seven_segment: streams Q23.16 words, predicts
// the five segment bytes and the overflow flag, and checks each result in order.
// Depends on num7seg_pkg and the number_to_seven_segment RTL only.
module number_to_seven_segment_test;
    timeunit 1ns;
    timeprecision 1ps;

    import num7seg_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_WORDS   = 125;

    localparam logic [4:0] PHASE_BASE [8] = '{5'd2, 5'd16, 5'd2, 5'd16, 5'd0, 5'd1, 5'd17, 5'd31};
    localparam logic [2:0] PHASE_FRAC [8] = '{3'd0, 3'd7, 3'd7, 3'd0, 3'd3, 3'd5, 3'd2, 3'd6};

    typedef struct packed {
        logic             ovf;
        logic [4:0][7:0]  seg;   // seg[0] is the leftmost slot
    } panel_t;

    class segment_scoreboard;
        logic [4:0] base_reg = BASE_RESET;
        logic [2:0] frac_reg = FRAC_RESET;
        panel_t     expected_q[$];
        int         checked    = 0;
        int         overflows  = 0;
        int         mismatches = 0;

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_NUMBER_BASE)
                base_reg = data[4:0];
            else if (idx == CFG_FRACTION_DIGITS)
                frac_reg = data[2:0];
        endfunction

        function int clamped_radix();
            if (base_reg < 5'd2)
                return 2;
            if (base_reg > 5'd16)
                return 16;
            return int'(base_reg);
        endfunction

        function logic [7:0] shape(logic [3:0] d);
            case (d)
                4'h0: return 8'h3F;
                4'h1: return 8'h06;
                4'h2: return 8'h5B;
                4'h3: return 8'h4F;
                4'h4: return 8'h66;
                4'h5: return 8'h6D;
                4'h6: return 8'h7D;
                4'h7: return 8'h07;
                4'h8: return 8'h7F;
                4'h9: return 8'h6F;
                4'hA: return 8'h5F;
                4'hB: return 8'h7C;
                4'hC: return 8'h39;
                4'hD: return 8'h5E;
                4'hE: return 8'h79;
                default: return 8'h71;
            endcase
        endfunction

        function panel_t format_value(logic [39:0] raw);
            panel_t     p;
            logic       neg;
            logic       big;
            logic [39:0] mag40;
            logic [63:0] mag, radix, limit, prod, num;
            logic [7:0] bits;
            int         f, i, pos, fit_f;
            neg   = raw[39];
            mag40 = neg ? (40'd0 - raw) : raw;
            mag   = {24'd0, mag40};
            radix = 64'(clamped_radix());
            limit = 64'd1;
            repeat (neg ? 3 : 4) limit = limit * radix;
            limit = limit << 16;
            fit_f = -1;
            num   = 64'd0;
            for (f = int'(frac_reg); f >= 0 && fit_f < 0; f--) begin
                prod = mag;
                big  = 1'b0;
                for (i = 0; i < f && !big; i++) begin
                    if (prod >= limit)
                        big = 1'b1;
                    else
                        prod = prod * radix;
                end
                if (!big && prod + 64'd32768 < limit) begin
                    num   = (prod + 64'd32768) >> 16;
                    fit_f = f;
                end
            end
            p.seg = '0;
            p.ovf = (fit_f < 0);
            if (p.ovf) begin
                p.seg[0] = SEG_MINUS;
                p.seg[1] = SEG_MINUS;
                p.seg[3] = SEG_MINUS;
                p.seg[4] = SEG_MINUS;
                return p;
            end
            pos = 4;
            i   = 0;
            while (num != 0 || i <= fit_f) begin
                bits = shape(4'(num % radix));
                if (fit_f != 0 && i == fit_f)
                    bits = bits | SEG_DOT;
                if (pos >= 0)
                    p.seg[pos] = bits;
                pos--;
                if (pos == 2) begin
                    p.seg[2] = SEG_BLANK;
                    pos--;
                end
                num = num / radix;
                i++;
            end
            if (neg) begin
                if (pos >= 0)
                    p.seg[pos] = SEG_MINUS;
                pos--;
            end
            while (pos >= 0) begin
                p.seg[pos] = SEG_BLANK;
                pos--;
            end
            return p;
        endfunction

        function void note_value(logic [39:0] raw);
            expected_q.push_back(format_value(raw));
        endfunction

        function void report_mismatch(string what, logic [7:0] want, logic [7:0] got);
            mismatches++;
            $display("%0t: %s expected %02h actual %02h", $time, what, want, got);
        endfunction

        function void check_panel(logic [39:0] got_seg, logic got_ovf);
            panel_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word, seg_pos0", 8'h00, got_seg[7:0]);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (want.ovf)
                overflows++;
            for (int k = 0; k < 5; k++) begin
                if (got_seg[8*k +: 8] !== want.seg[k])
                    report_mismatch($sformatf("seg_pos%0d", k), want.seg[k], got_seg[8*k +: 8]);
            end
            if (got_ovf !== want.ovf)
                report_mismatch("overflow", 8'(want.ovf), 8'(got_ovf));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [VALUE_W-1:0]      s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [TDATA_W-1:0]      m_tdata;
    logic [TUSER_W-1:0]      m_tuser;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    segment_scoreboard board = new();
    bit  tx_idle     = 1'b1;
    bit  rx_idle     = 1'b1;
    int  rx_hold     = 0;
    int  quiet_count = 0;
    int  settings    = 1;

    number_to_seven_segment u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // log-spread magnitudes, fit-boundary magnitudes, small numbers and raw noise
    function automatic logic [39:0] random_value(int radix, int frac);
        logic [39:0] bits40, mag;
        logic [63:0] lim, scale;
        logic        neg;
        int          r;
        bits40 = {8'($urandom()), 32'($urandom())};
        neg    = 1'($urandom_range(0, 1));
        r      = $urandom_range(0, 99);
        if (r < 10)
            return bits40;
        if (r < 50) begin
            mag     = bits40 >> $urandom_range(0, 39);
            mag[39] = 1'b0;
        end else if (r < 65) begin
            mag = 40'($urandom_range(0, 1 << 18));
        end else begin
            lim = 64'd1;
            repeat (neg ? 3 : 4) lim = lim * 64'(radix);
            lim   = lim << 16;
            scale = 64'd1;
            repeat ($urandom_range(0, frac)) scale = scale * 64'(radix);
            mag = 40'((lim - 64'd32768) / scale) + 40'($urandom_range(0, 6)) - 40'd3;
        end
        return neg ? (40'd0 - mag) : mag;
    endfunction

    task automatic send_word(input logic [VALUE_W-1:0] v);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= v;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_value(v);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_config(input logic [4:0] radix, input logic [2:0] frac);
        cfg_index <= CFG_NUMBER_BASE;
        cfg_data  <= radix;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(CFG_NUMBER_BASE, radix);
        cfg_index <= CFG_FRACTION_DIGITS;
        cfg_data  <= {2'b00, frac};
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(CFG_FRACTION_DIGITS, {2'b00, frac});
        cfg_valid <= 1'b0;
        settings++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_panel(m_tdata, m_tuser[0]);
        if (!rx_idle) begin
            m_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else if ($urandom_range(0, 99) < 25) begin
            m_tready <= 1'b0;
            rx_hold = pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_count = 0;
        else
            quiet_count++;
        if (quiet_count >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [4:0] radix;
        logic [2:0] frac;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: base 10, two fraction digits
        send_word(40'd0);
        send_word(40'h00_0001_0000);
        send_word(40'h00_0063_FD70);
        send_word(40'h00_270F_6666);               // fits only with no fraction digits
        send_word(40'h00_270F_8000);               // rounds past four digits
        send_word(40'h7F_FFFF_FFFF);
        send_word(40'h80_0000_0000);
        send_word(40'hFF_FFFF_FFFF);               // minus sign on a zero
        send_word(40'd0 - 40'h00_03E7_6666);
        send_word(40'd0 - 40'h00_000C_5852);
        wait_drain();

        write_config(5'd16, 3'd0);                 // hex glyphs, no point
        send_word(40'h00_ABCD_0000);
        send_word(40'h00_EF12_0000);
        send_word(40'h00_0000_8000);
        send_word(40'd0 - 40'h00_0FFF_0000);
        wait_drain();

        write_config(5'd2, 3'd7);                  // leading zeros run off the left
        send_word(40'd0);
        send_word(40'h00_0000_0001);
        send_word(40'h00_0000_C000);
        send_word(40'd0 - 40'h00_0001_0000);
        wait_drain();

        write_config(5'd0, 3'd3);                  // base below range
        send_word(40'h00_0003_0000);
        send_word(40'h00_000F_0000);
        wait_drain();

        write_config(5'd31, 3'd7);                 // base above range
        send_word(40'h00_0000_1234);
        send_word(40'd0 - 40'h00_0000_0001);
        wait_drain();

        write_config(5'd1, 3'd5);
        send_word(40'h00_0007_8000);
        wait_drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < 8) begin
                radix = PHASE_BASE[ph];
                frac  = PHASE_FRAC[ph];
            end else begin
                radix = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                    : 5'($urandom_range(2, 16));
                frac  = 3'($urandom_range(0, 7));
            end
            tx_idle = (ph % 3 != 1);
            rx_idle = (ph % 3 != 1);
            write_config(radix, frac);
            repeat (PHASE_WORDS) send_word(random_value(board.clamped_radix(), board.frac_reg));
            wait_drain();
        end

        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (40) @(posedge aclk);
        $display("summary: %0d words checked under %0d register settings, %0d overflowed",
                 board.checked, settings, board.overflows);
        $display("summary: %0d field mismatches, %0d words still awaited",
                 board.mismatches, board.pending());
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
